### rtl/core/sci_pkg.sv
// sci_pkg: shared constants and types for the segment/circle intersection block
// holds the default coordinate width and the configuration register indexes
// no dependencies
`default_nettype none

package sci_pkg;

  // default coordinate width of all fixed point fields
  localparam int COORD_WIDTH_DEF = 24;

  // width of the configuration register index
  localparam int REG_IDX_W = 2;

  // configuration register indexes
  typedef enum logic [REG_IDX_W-1:0] {
    REG_CENTER_X = 2'd0,
    REG_CENTER_Y = 2'd1,
    REG_RADIUS   = 2'd2
  } reg_idx_t;

endpackage

`default_nettype wire

### rtl/core/sci_umul.sv
// sci_umul: two unsigned multipliers split into half-width partial products
// two register stages (partial products, then their sum) with a side payload
// no dependencies
`default_nettype none

module sci_umul #(
  parameter int A_WIDTH   = 25,
  parameter int B_WIDTH   = 25,
  parameter int PAY_WIDTH = 1
) (
  input  wire logic                                   clk,
  input  wire logic                                   en,
  input  wire logic [1:0][A_WIDTH-1:0]                op_a,
  input  wire logic [1:0][B_WIDTH-1:0]                op_b,
  input  wire logic [PAY_WIDTH-1:0]                   pay_i,
  output logic      [1:0][A_WIDTH+B_WIDTH-1:0]        prod_o,
  output logic      [PAY_WIDTH-1:0]                   pay_o
);

  localparam int AL     = A_WIDTH / 2;
  localparam int AH     = A_WIDTH - AL;
  localparam int BL     = B_WIDTH / 2;
  localparam int BH     = B_WIDTH - BL;
  localparam int PROD_W = A_WIDTH + B_WIDTH;

  logic [1:0][AL+BL-1:0]  pp_ll_r;
  logic [1:0][AL+BH-1:0]  pp_lh_r;
  logic [1:0][AH+BL-1:0]  pp_hl_r;
  logic [1:0][AH+BH-1:0]  pp_hh_r;
  logic [1:0][PROD_W-1:0] prod_nxt;
  logic [1:0][PROD_W-1:0] prod_r;
  logic [PAY_WIDTH-1:0]   pay1_r;
  logic [PAY_WIDTH-1:0]   pay2_r;

  for (genvar g = 0; g < 2; g++) begin : g_mul
    // partial products of the low and high halves
    always_ff @(posedge clk) begin
      if (en) begin
        pp_ll_r[g] <= op_a[g][AL-1:0] * op_b[g][BL-1:0];
        pp_lh_r[g] <= op_a[g][AL-1:0] * op_b[g][B_WIDTH-1:BL];
        pp_hl_r[g] <= op_a[g][A_WIDTH-1:AL] * op_b[g][BL-1:0];
        pp_hh_r[g] <= op_a[g][A_WIDTH-1:AL] * op_b[g][B_WIDTH-1:BL];
      end
    end

    // aligned sum of the partial products
    always_comb begin
      prod_nxt[g] = (PROD_W'(pp_hh_r[g]) << (AL + BL))
                  + (PROD_W'(pp_hl_r[g]) << AL)
                  + (PROD_W'(pp_lh_r[g]) << BL)
                  + PROD_W'(pp_ll_r[g]);
    end
  end

  // second stage and payload alignment
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
      pay1_r <= pay_i;
      pay2_r <= pay1_r;
    end
  end

  assign prod_o = prod_r;
  assign pay_o  = pay2_r;

endmodule

`default_nettype wire

### rtl/core/sci_sqrt_cell.sv
// sci_sqrt_cell: one digit of a pipelined integer square root
// takes the next two radicand bits, settles one root bit, passes all on
// no dependencies
`default_nettype none

module sci_sqrt_cell #(
  parameter int ROOT_W = 50,
  parameter int PAY_W  = 1
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  en,
  input  wire logic                  v_i,
  input  wire logic [ROOT_W-1:0]     root_i,
  input  wire logic [ROOT_W:0]       rem_i,
  input  wire logic [2*ROOT_W-1:0]   disc_i,
  input  wire logic [PAY_W-1:0]      pay_i,
  output logic                       v_o,
  output logic      [ROOT_W-1:0]     root_o,
  output logic      [ROOT_W:0]       rem_o,
  output logic      [2*ROOT_W-1:0]   disc_o,
  output logic      [PAY_W-1:0]      pay_o
);

  localparam int DISC_W = 2 * ROOT_W;
  localparam int REM_W  = ROOT_W + 1;
  localparam int TRY_W  = ROOT_W + 3;

  logic [TRY_W-1:0]  cur;
  logic [TRY_W-1:0]  trial;
  logic [TRY_W-1:0]  diff;
  logic              ge;
  logic [REM_W-1:0]  rem_nxt;
  logic [ROOT_W-1:0] root_nxt;
  logic [DISC_W-1:0] disc_nxt;
  logic              v_r;
  logic [ROOT_W-1:0] root_r;
  logic [REM_W-1:0]  rem_r;
  logic [DISC_W-1:0] disc_r;
  logic [PAY_W-1:0]  pay_r;

  // trial subtract of 4*root+1 from the shifted remainder
  always_comb begin
    cur      = {rem_i, disc_i[DISC_W-1 -: 2]};
    trial    = {1'b0, root_i, 2'b01};
    diff     = cur - trial;
    ge       = (cur >= trial);
    rem_nxt  = ge ? diff[REM_W-1:0] : cur[REM_W-1:0];
    root_nxt = {root_i[ROOT_W-2:0], ge};
    disc_nxt = {disc_i[DISC_W-3:0], 2'b00};
  end

  // valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_i;
    end
  end

  // data registers
  always_ff @(posedge clk) begin
    if (en) begin
      root_r <= root_nxt;
      rem_r  <= rem_nxt;
      disc_r <= disc_nxt;
      pay_r  <= pay_i;
    end
  end

  assign v_o    = v_r;
  assign root_o = root_r;
  assign rem_o  = rem_r;
  assign disc_o = disc_r;
  assign pay_o  = pay_r;

endmodule

`default_nettype wire

### rtl/core/sci_div_cell.sv
// sci_div_cell: one quotient bit of a pipelined restoring divider, x and y axes
// both axes share the divisor, which travels down the row with the item
// no dependencies
`default_nettype none

module sci_div_cell #(
  parameter int DIV_W = 49,
  parameter int LOW_W = 24,
  parameter int PAY_W = 3
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      en,
  input  wire logic                      v_i,
  input  wire logic [DIV_W-1:0]          dvs_i,
  input  wire logic [1:0][DIV_W-1:0]     rem_i,
  input  wire logic [1:0][LOW_W-1:0]     low_i,
  input  wire logic [1:0][LOW_W-1:0]     quo_i,
  input  wire logic [PAY_W-1:0]          pay_i,
  output logic                           v_o,
  output logic      [DIV_W-1:0]          dvs_o,
  output logic      [1:0][DIV_W-1:0]     rem_o,
  output logic      [1:0][LOW_W-1:0]     low_o,
  output logic      [1:0][LOW_W-1:0]     quo_o,
  output logic      [PAY_W-1:0]          pay_o
);

  logic [1:0][DIV_W:0]   cur;
  logic [1:0][DIV_W:0]   diff;
  logic [1:0]            ge;
  logic [DIV_W:0]        dvs_ext;
  logic [1:0][DIV_W-1:0] rem_nxt;
  logic [1:0][LOW_W-1:0] low_nxt;
  logic [1:0][LOW_W-1:0] quo_nxt;
  logic                  v_r;
  logic [DIV_W-1:0]      dvs_r;
  logic [1:0][DIV_W-1:0] rem_r;
  logic [1:0][LOW_W-1:0] low_r;
  logic [1:0][LOW_W-1:0] quo_r;
  logic [PAY_W-1:0]      pay_r;

  // shift in the next dividend bit, subtract the divisor when it fits
  always_comb begin
    dvs_ext = {1'b0, dvs_i};
    for (int g = 0; g < 2; g++) begin
      cur[g]     = {rem_i[g], low_i[g][LOW_W-1]};
      diff[g]    = cur[g] - dvs_ext;
      ge[g]      = (cur[g] >= dvs_ext);
      rem_nxt[g] = ge[g] ? diff[g][DIV_W-1:0] : cur[g][DIV_W-1:0];
      low_nxt[g] = {low_i[g][LOW_W-2:0], 1'b0};
      quo_nxt[g] = {quo_i[g][LOW_W-2:0], ge[g]};
    end
  end

  // valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_i;
    end
  end

  // data registers
  always_ff @(posedge clk) begin
    if (en) begin
      dvs_r <= dvs_i;
      rem_r <= rem_nxt;
      low_r <= low_nxt;
      quo_r <= quo_nxt;
      pay_r <= pay_i;
    end
  end

  assign v_o   = v_r;
  assign dvs_o = dvs_r;
  assign rem_o = rem_r;
  assign low_o = low_r;
  assign quo_o = quo_r;
  assign pay_o = pay_r;

endmodule

`default_nettype wire

### rtl/core/segment_circle_intersect.sv
// segment_circle_intersect: top level of the segment against circle test
// uses sci_pkg, sci_umul, sci_sqrt_cell and sci_div_cell
`default_nettype none

// Usage
// - configuration: write center_x (index 0), center_y (1) and circle_radius (2)
//   on cfg_valid/cfg_index/cfg_data; cfg_ready is always high, other indexes are
//   ignored. Write only while no item is in flight.
// - input: one segment per item on in_valid/in_stall (start and end points).
// - output: one item per segment on out_valid/out_stall: hit flag and nearest
//   intersection point, point is zero when there is no hit.
// - structure: a square root row (2*COORD_WIDTH+2 cells) and a divider row
//   (COORD_WIDTH cells) lie between acceptance and out_valid, behind the front
//   stages and the multipliers.
// - throughput: one item per cycle while in_stall is low; all stages move together.
// - stall: a result waiting on a stalled receiver stays in the output register
//   while the pipeline keeps moving; the next result goes into a skid register,
//   and only while that skid register is full is in_stall high and the whole
//   pipeline held.
// - reset: synchronous, active low; clears all valid bits (output and skid too)
//   and the circle registers to zero.
module segment_circle_intersect #(
  parameter int COORD_WIDTH = sci_pkg::COORD_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [sci_pkg::REG_IDX_W-1:0] cfg_index,
  input  wire logic [COORD_WIDTH-1:0]        cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic signed [COORD_WIDTH-1:0] in_start_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_start_y,
  input  wire logic signed [COORD_WIDTH-1:0] in_end_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_end_y,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               out_hit,
  output logic signed [COORD_WIDTH-1:0]      out_hit_x,
  output logic signed [COORD_WIDTH-1:0]      out_hit_y
);

  localparam int CW     = COORD_WIDTH;
  localparam int DW     = CW + 1;
  localparam int SW     = 2 * CW + 2;
  localparam int AW     = 2 * CW + 1;
  localparam int DSW    = 2 * SW;
  localparam int QW     = SW;
  localparam int NW     = SW + 2;
  localparam int MW     = AW + CW;
  localparam int NMW    = MW + 2;
  localparam int PAY1_W = 2 + SW + AW + 2 * DW + 2 * CW;
  localparam int PAYS_W = 1 + SW + AW + 2 * DW + 2 * CW;

  logic en;

  // ---------------------------------------------------------------- config
  logic signed [CW-1:0] cx_r;
  logic signed [CW-1:0] cy_r;
  logic [CW-2:0]        rad_r;

  assign cfg_ready = 1'b1;

  // circle registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r  <= '0;
      cy_r  <= '0;
      rad_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        sci_pkg::REG_CENTER_X: cx_r  <= cfg_data;
        sci_pkg::REG_CENTER_Y: cy_r  <= cfg_data;
        sci_pkg::REG_RADIUS:   rad_r <= cfg_data[CW-2:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- stage 1
  logic signed [DW-1:0] dx_nxt, dy_nxt, fx_nxt, fy_nxt;
  logic                 v1_r;
  logic signed [DW-1:0] dx1_r, dy1_r, fx1_r, fy1_r;
  logic signed [CW-1:0] sx1_r, sy1_r;

  // direction and offset from the center
  always_comb begin
    dx_nxt = {in_end_x[CW-1], in_end_x} - {in_start_x[CW-1], in_start_x};
    dy_nxt = {in_end_y[CW-1], in_end_y} - {in_start_y[CW-1], in_start_y};
    fx_nxt = {in_start_x[CW-1], in_start_x} - {cx_r[CW-1], cx_r};
    fy_nxt = {in_start_y[CW-1], in_start_y} - {cy_r[CW-1], cy_r};
  end

  // ---------------------------------------------------------------- stage 2
  logic                 v2_r;
  logic signed [SW-1:0] pdx2_r, pdy2_r, phx2_r, phy2_r, pfx2_r, pfy2_r;
  logic [2*CW-3:0]      prr2_r;
  logic signed [DW-1:0] dx2_r, dy2_r;
  logic signed [CW-1:0] sx2_r, sy2_r;

  // ---------------------------------------------------------------- stage 3
  logic [SW-1:0]        a_sum;
  logic signed [SW-1:0] h_nxt, c_nxt;
  logic                 v3_r;
  logic [AW-1:0]        a3_r;
  logic signed [SW-1:0] h3_r, c3_r;
  logic signed [DW-1:0] dx3_r, dy3_r;
  logic signed [CW-1:0] sx3_r, sy3_r;

  // a = d.d, h = f.d, c = f.f - r^2
  always_comb begin
    a_sum = pdx2_r + pdy2_r;
    h_nxt = phx2_r + phy2_r;
    c_nxt = pfx2_r + pfy2_r - SW'(prr2_r);
  end

  // ---------------------------------------------------------------- stage 4
  logic [SW-1:0]        h_abs, c_abs;
  logic                 v4_r;
  logic [AW-1:0]        hm4_r, cm4_r, a4_r;
  logic                 cneg4_r, az4_r;
  logic signed [SW-1:0] h4_r;
  logic signed [DW-1:0] dx4_r, dy4_r;
  logic signed [CW-1:0] sx4_r, sy4_r;

  // magnitudes for the unsigned multipliers
  always_comb begin
    h_abs = h3_r[SW-1] ? -h3_r : h3_r;
    c_abs = c3_r[SW-1] ? -c3_r : c3_r;
  end

  // front pipeline registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx1_r   <= dx_nxt;
      dy1_r   <= dy_nxt;
      fx1_r   <= fx_nxt;
      fy1_r   <= fy_nxt;
      sx1_r   <= in_start_x;
      sy1_r   <= in_start_y;
      pdx2_r  <= dx1_r * dx1_r;
      pdy2_r  <= dy1_r * dy1_r;
      phx2_r  <= fx1_r * dx1_r;
      phy2_r  <= fy1_r * dy1_r;
      pfx2_r  <= fx1_r * fx1_r;
      pfy2_r  <= fy1_r * fy1_r;
      prr2_r  <= rad_r * rad_r;
      dx2_r   <= dx1_r;
      dy2_r   <= dy1_r;
      sx2_r   <= sx1_r;
      sy2_r   <= sy1_r;
      a3_r    <= a_sum[AW-1:0];
      h3_r    <= h_nxt;
      c3_r    <= c_nxt;
      dx3_r   <= dx2_r;
      dy3_r   <= dy2_r;
      sx3_r   <= sx2_r;
      sy3_r   <= sy2_r;
      hm4_r   <= h_abs[AW-1:0];
      cm4_r   <= c_abs[AW-1:0];
      cneg4_r <= c3_r[SW-1];
      az4_r   <= (a3_r == '0);
      a4_r    <= a3_r;
      h4_r    <= h3_r;
      dx4_r   <= dx3_r;
      dy4_r   <= dy3_r;
      sx4_r   <= sx3_r;
      sy4_r   <= sy3_r;
    end
  end

  // ---------------------------------------------------------------- h^2 and a*|c|
  logic [1:0][2*AW-1:0] m1_prod;
  logic [PAY1_W-1:0]    m1_pay;
  logic                 v5_r, v6_r;
  logic                 u1_az, u1_cneg;
  logic signed [SW-1:0] u1_h;
  logic [AW-1:0]        u1_a;
  logic signed [DW-1:0] u1_dx, u1_dy;
  logic signed [CW-1:0] u1_sx, u1_sy;

  sci_umul #(
    .A_WIDTH   (AW),
    .B_WIDTH   (AW),
    .PAY_WIDTH (PAY1_W)
  ) u_mul_disc (
    .clk    (clk),
    .en     (en),
    .op_a   ({a4_r, hm4_r}),
    .op_b   ({cm4_r, hm4_r}),
    .pay_i  ({az4_r, cneg4_r, h4_r, a4_r, dx4_r, dy4_r, sx4_r, sy4_r}),
    .prod_o (m1_prod),
    .pay_o  (m1_pay)
  );

  assign {u1_az, u1_cneg, u1_h, u1_a, u1_dx, u1_dy, u1_sx, u1_sy} = m1_pay;

  // ---------------------------------------------------------------- stage 7
  logic [DSW-1:0]       hh_ext, ac_ext, disc_nxt;
  logic                 v7_r;
  logic [DSW-1:0]       disc7_r;
  logic                 nohit7_r;
  logic signed [SW-1:0] h7_r;
  logic [AW-1:0]        a7_r;
  logic signed [DW-1:0] dx7_r, dy7_r;
  logic signed [CW-1:0] sx7_r, sy7_r;

  // quarter discriminant h^2 - a*c
  always_comb begin
    hh_ext   = DSW'(m1_prod[0]);
    ac_ext   = DSW'(m1_prod[1]);
    disc_nxt = u1_cneg ? (hh_ext + ac_ext) : (hh_ext - ac_ext);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
    end else if (en) begin
      v5_r <= v4_r;
      v6_r <= v5_r;
      v7_r <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      disc7_r  <= disc_nxt;
      nohit7_r <= u1_az | disc_nxt[DSW-1];
      h7_r     <= u1_h;
      a7_r     <= u1_a;
      dx7_r    <= u1_dx;
      dy7_r    <= u1_dy;
      sx7_r    <= u1_sx;
      sy7_r    <= u1_sy;
    end
  end

  // ---------------------------------------------------------------- square root row
  logic              sq_v    [QW+1];
  logic [QW-1:0]     sq_root [QW+1];
  logic [QW:0]       sq_rem  [QW+1];
  logic [DSW-1:0]    sq_disc [QW+1];
  logic [PAYS_W-1:0] sq_pay  [QW+1];

  assign sq_v[0]    = v7_r;
  assign sq_root[0] = '0;
  assign sq_rem[0]  = '0;
  assign sq_disc[0] = disc7_r;
  assign sq_pay[0]  = {nohit7_r, h7_r, a7_r, dx7_r, dy7_r, sx7_r, sy7_r};

  for (genvar i = 0; i < QW; i++) begin : g_sqrt
    sci_sqrt_cell #(
      .ROOT_W (QW),
      .PAY_W  (PAYS_W)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .v_i    (sq_v[i]),
      .root_i (sq_root[i]),
      .rem_i  (sq_rem[i]),
      .disc_i (sq_disc[i]),
      .pay_i  (sq_pay[i]),
      .v_o    (sq_v[i+1]),
      .root_o (sq_root[i+1]),
      .rem_o  (sq_rem[i+1]),
      .disc_o (sq_disc[i+1]),
      .pay_o  (sq_pay[i+1])
    );
  end

  // ---------------------------------------------------------------- root selection
  logic                 s_nohit;
  logic signed [SW-1:0] s_h;
  logic [AW-1:0]        s_a;
  logic signed [DW-1:0] s_dx, s_dy;
  logic signed [CW-1:0] s_sx, s_sy;
  logic [NW-1:0]        h_ne, s_ne, a_ne, n1, n2;
  logic                 ok1, ok2;
  logic [AW-1:0]        n_nxt;
  logic [DW-1:0]        dxa, dya;
  logic [CW-1:0]        sxa, sya;
  logic                 v8_r;
  logic                 hit8_r;
  logic [AW-1:0]        n8_r, a8_r;
  logic [CW-1:0]        sxm8_r, sym8_r, dxm8_r, dym8_r;
  logic                 sxn8_r, syn8_r, dxn8_r, dyn8_r;

  assign {s_nohit, s_h, s_a, s_dx, s_dy, s_sx, s_sy} = sq_pay[QW];

  // numerators -h - s and -h + s, keep the first one inside [0, a]
  always_comb begin
    h_ne  = {{(NW-SW){s_h[SW-1]}}, s_h};
    s_ne  = NW'(sq_root[QW]);
    a_ne  = NW'(s_a);
    n1    = -h_ne - s_ne;
    n2    = s_ne - h_ne;
    ok1   = !n1[NW-1] && (n1 <= a_ne);
    ok2   = !n2[NW-1] && (n2 <= a_ne);
    n_nxt = ok1 ? n1[AW-1:0] : n2[AW-1:0];
    dxa   = s_dx[DW-1] ? -s_dx : s_dx;
    dya   = s_dy[DW-1] ? -s_dy : s_dy;
    sxa   = s_sx[CW-1] ? -s_sx : s_sx;
    sya   = s_sy[CW-1] ? -s_sy : s_sy;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit8_r <= !s_nohit && (ok1 || ok2);
      n8_r   <= n_nxt;
      a8_r   <= s_a;
      sxm8_r <= sxa;
      sym8_r <= sya;
      dxm8_r <= dxa[CW-1:0];
      dym8_r <= dya[CW-1:0];
      sxn8_r <= s_sx[CW-1];
      syn8_r <= s_sy[CW-1];
      dxn8_r <= s_dx[DW-1];
      dyn8_r <= s_dy[DW-1];
    end
  end

  // ---------------------------------------------------------------- start*a and n*d
  logic [1:0][MW-1:0] mx_prod, my_prod;
  logic [4:0]         mx_pay;
  logic [AW-1:0]      my_pay;
  logic               v9_r, v10_r;
  logic               p_hit, p_sxn, p_dxn, p_syn, p_dyn;

  sci_umul #(
    .A_WIDTH   (AW),
    .B_WIDTH   (CW),
    .PAY_WIDTH (5)
  ) u_mul_px (
    .clk    (clk),
    .en     (en),
    .op_a   ({n8_r, a8_r}),
    .op_b   ({dxm8_r, sxm8_r}),
    .pay_i  ({hit8_r, sxn8_r, dxn8_r, syn8_r, dyn8_r}),
    .prod_o (mx_prod),
    .pay_o  (mx_pay)
  );

  sci_umul #(
    .A_WIDTH   (AW),
    .B_WIDTH   (CW),
    .PAY_WIDTH (AW)
  ) u_mul_py (
    .clk    (clk),
    .en     (en),
    .op_a   ({n8_r, a8_r}),
    .op_b   ({dym8_r, sym8_r}),
    .pay_i  (a8_r),
    .prod_o (my_prod),
    .pay_o  (my_pay)
  );

  assign {p_hit, p_sxn, p_dxn, p_syn, p_dyn} = mx_pay;

  // ---------------------------------------------------------------- numerators
  logic [NMW-1:0] tx0, tx1, ty0, ty1;
  logic           v11_r, v12_r;
  logic [NMW-1:0] numx11_r, numy11_r;
  logic           hit11_r, hit12_r;
  logic [AW-1:0]  a11_r, a12_r;
  logic [NMW-1:0] magx, magy;
  logic [MW-1:0]  mx12_r, my12_r;
  logic           negx12_r, negy12_r;

  // signed terms of start*a + n*d
  always_comb begin
    tx0  = p_sxn ? -NMW'(mx_prod[0]) : NMW'(mx_prod[0]);
    tx1  = p_dxn ? -NMW'(mx_prod[1]) : NMW'(mx_prod[1]);
    ty0  = p_syn ? -NMW'(my_prod[0]) : NMW'(my_prod[0]);
    ty1  = p_dyn ? -NMW'(my_prod[1]) : NMW'(my_prod[1]);
    magx = numx11_r[NMW-1] ? -numx11_r : numx11_r;
    magy = numy11_r[NMW-1] ? -numy11_r : numy11_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v8_r  <= 1'b0;
      v9_r  <= 1'b0;
      v10_r <= 1'b0;
      v11_r <= 1'b0;
      v12_r <= 1'b0;
    end else if (en) begin
      v8_r  <= sq_v[QW];
      v9_r  <= v8_r;
      v10_r <= v9_r;
      v11_r <= v10_r;
      v12_r <= v11_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      numx11_r <= tx0 + tx1;
      numy11_r <= ty0 + ty1;
      hit11_r  <= p_hit;
      a11_r    <= my_pay;
      mx12_r   <= magx[MW-1:0];
      my12_r   <= magy[MW-1:0];
      negx12_r <= numx11_r[NMW-1];
      negy12_r <= numy11_r[NMW-1];
      hit12_r  <= hit11_r;
      a12_r    <= a11_r;
    end
  end

  // ---------------------------------------------------------------- divider row
  logic                  dv_v   [CW+1];
  logic [AW-1:0]         dv_dvs [CW+1];
  logic [1:0][AW-1:0]    dv_rem [CW+1];
  logic [1:0][CW-1:0]    dv_low [CW+1];
  logic [1:0][CW-1:0]    dv_quo [CW+1];
  logic [2:0]            dv_pay [CW+1];

  assign dv_v[0]   = v12_r;
  assign dv_dvs[0] = a12_r;
  assign dv_rem[0] = {my12_r[MW-1:CW], mx12_r[MW-1:CW]};
  assign dv_low[0] = {my12_r[CW-1:0], mx12_r[CW-1:0]};
  assign dv_quo[0] = '0;
  assign dv_pay[0] = {hit12_r, negx12_r, negy12_r};

  for (genvar i = 0; i < CW; i++) begin : g_div
    sci_div_cell #(
      .DIV_W (AW),
      .LOW_W (CW),
      .PAY_W (3)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .v_i   (dv_v[i]),
      .dvs_i (dv_dvs[i]),
      .rem_i (dv_rem[i]),
      .low_i (dv_low[i]),
      .quo_i (dv_quo[i]),
      .pay_i (dv_pay[i]),
      .v_o   (dv_v[i+1]),
      .dvs_o (dv_dvs[i+1]),
      .rem_o (dv_rem[i+1]),
      .low_o (dv_low[i+1]),
      .quo_o (dv_quo[i+1]),
      .pay_o (dv_pay[i+1])
    );
  end

  // ---------------------------------------------------------------- result
  logic                 t_hit, t_negx, t_negy;
  logic [CW-1:0]        t_qx, t_qy;
  logic                 tail_v;
  logic                 tail_hit;
  logic signed [CW-1:0] tail_x, tail_y;

  assign {t_hit, t_negx, t_negy} = dv_pay[CW];

  // restore sign (truncated toward zero), zero the point on a miss
  always_comb begin
    tail_v   = dv_v[CW];
    t_qx     = dv_quo[CW][0];
    t_qy     = dv_quo[CW][1];
    tail_hit = t_hit;
    tail_x   = t_hit ? (t_negx ? -t_qx : t_qx) : '0;
    tail_y   = t_hit ? (t_negy ? -t_qy : t_qy) : '0;
  end

  // ---------------------------------------------------------------- output and skid
  logic                 out_valid_r, skid_valid_r;
  logic                 out_hit_r, skid_hit_r;
  logic signed [CW-1:0] out_x_r, out_y_r, skid_x_r, skid_y_r;
  logic                 take;

  assign take     = out_valid_r && !out_stall;
  assign en       = !skid_valid_r;
  assign in_stall = skid_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (take) begin
        skid_valid_r <= 1'b0;
      end
    end else if (!out_valid_r || take) begin
      out_valid_r <= tail_v;
    end else if (tail_v) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (take) begin
        out_hit_r <= skid_hit_r;
        out_x_r   <= skid_x_r;
        out_y_r   <= skid_y_r;
      end
    end else if (!out_valid_r || take) begin
      out_hit_r <= tail_hit;
      out_x_r   <= tail_x;
      out_y_r   <= tail_y;
    end else begin
      skid_hit_r <= tail_hit;
      skid_x_r   <= tail_x;
      skid_y_r   <= tail_y;
    end
  end

  assign out_valid = out_valid_r;
  assign out_hit   = out_hit_r;
  assign out_hit_x = out_x_r;
  assign out_hit_y = out_y_r;

endmodule

`default_nettype wire

### rtl/core/sci_checker.sv
// sci_checker: port-level checks for segment_circle_intersect
// uses sci_pkg; bound to the top level at the end of this file
`default_nettype none

module sci_checker #(
  parameter int COORD_WIDTH = sci_pkg::COORD_WIDTH_DEF
) (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_stall,
  input wire logic                          out_valid,
  input wire logic                          out_stall,
  input wire logic                          out_hit,
  input wire logic signed [COORD_WIDTH-1:0] out_hit_x,
  input wire logic signed [COORD_WIDTH-1:0] out_hit_y
);

  // reset empties the output side
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("output or stall active after reset");

  // a miss reports the origin
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> out_hit_x == '0 && out_hit_y == '0)
    else $error("miss item with nonzero point");

  // input is only held back when a result is waiting
  a_stall_needs_output: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_hit) &&
      $stable(out_hit_x) && $stable(out_hit_y))
    else $error("stalled output item changed");

endmodule

bind segment_circle_intersect sci_checker #(
  .COORD_WIDTH (COORD_WIDTH)
) u_sci_checker (.*);

`default_nettype wire

### tb/testbench.sv
// testbench: self-checking bench for segment_circle_intersect
// predicts hit flag and point with exact wide integer math, checks each result in order
// depends on sci_pkg and the segment_circle_intersect rtl
`timescale 1ns / 100ps

typedef logic signed [127:0] wide_t;

typedef struct packed {
  logic                hit;
  logic signed [23:0]  hit_x;
  logic signed [23:0]  hit_y;
} crossing_t;

class crossing_board;
  crossing_t   pending_q[$];
  logic signed [23:0] cx, cy;
  logic [22:0] radius;
  int          mismatches;
  int          checked;
  int          hits_seen;

  function new();
    cx = '0;
    cy = '0;
    radius = '0;
    mismatches = 0;
    checked = 0;
    hits_seen = 0;
  endfunction

  // register write as the block sees it, upper data bits dropped
  function void set_reg(logic [1:0] idx, logic [23:0] data);
    case (idx)
      sci_pkg::REG_CENTER_X: cx = data;
      sci_pkg::REG_CENTER_Y: cy = data;
      sci_pkg::REG_RADIUS:   radius = data[22:0];
      default: ;
    endcase
  endfunction

  function wide_t floor_sqrt(wide_t v);
    wide_t r, t;
    r = 0;
    for (int k = 56; k >= 0; k--) begin
      t = r | (wide_t'(1) <<< k);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  // nearest point of the segment on the circle, zero when none
  function crossing_t crossing(logic signed [23:0] sx, logic signed [23:0] sy,
                               logic signed [23:0] ex, logic signed [23:0] ey);
    wide_t dx, dy, fx, fy, rr, a, h, c, disc, s, n1, n2, n, qx, qy;
    crossing_t res;
    res = '0;
    dx = wide_t'(ex) - wide_t'(sx);
    dy = wide_t'(ey) - wide_t'(sy);
    fx = wide_t'(sx) - wide_t'(cx);
    fy = wide_t'(sy) - wide_t'(cy);
    rr = 0;
    rr[22:0] = radius;
    a = dx * dx + dy * dy;
    h = fx * dx + fy * dy;
    c = fx * fx + fy * fy - rr * rr;
    // zero-length segment never hits
    if (a == 0) return res;
    disc = h * h - a * c;
    if (disc < 0) return res;
    s = floor_sqrt(disc);
    n1 = -h - s;
    n2 = -h + s;
    // prefer the nearer root when it lies on the segment
    if (n1 >= 0 && n1 <= a) n = n1;
    else if (n2 >= 0 && n2 <= a) n = n2;
    else return res;
    qx = (wide_t'(sx) * a + n * dx) / a;
    qy = (wide_t'(sy) * a + n * dy) / a;
    res.hit = 1'b1;
    res.hit_x = qx[23:0];
    res.hit_y = qy[23:0];
    return res;
  endfunction

  function void note(logic signed [23:0] sx, logic signed [23:0] sy,
                     logic signed [23:0] ex, logic signed [23:0] ey);
    pending_q.push_back(crossing(sx, sy, ex, ey));
  endfunction

  task report(string what);
    $display("mismatch at %0t: %s", $time, what);
    mismatches++;
  endtask

  task check(logic hit, logic signed [23:0] hx, logic signed [23:0] hy);
    crossing_t want;
    if (pending_q.size() == 0) begin
      report("result with nothing outstanding");
      return;
    end
    want = pending_q.pop_front();
    checked++;
    if (hit) hits_seen++;
    if (hit !== want.hit)
      report($sformatf("hit %b, predicted %b", hit, want.hit));
    if (hx !== want.hit_x)
      report($sformatf("hit_x %0d, predicted %0d", hx, want.hit_x));
    if (hy !== want.hit_y)
      report($sformatf("hit_y %0d, predicted %0d", hy, want.hit_y));
  endtask
endclass

module testbench;
  localparam int CW = 24;
  localparam int SETTLE_CYCLES = 120;
  localparam int CYCLE_LIMIT = 600000;
  localparam logic [1:0] REG_SPARE = 2'd3;
  localparam logic signed [CW-1:0] C_MAX = 24'sh7fffff;
  localparam logic signed [CW-1:0] C_MIN = 24'sh800000;

  logic clk;
  logic rst_n;
  logic cfg_valid;
  logic cfg_ready;
  logic [sci_pkg::REG_IDX_W-1:0] cfg_index;
  logic [CW-1:0] cfg_data;
  logic in_valid;
  logic in_stall;
  logic signed [CW-1:0] in_start_x, in_start_y, in_end_x, in_end_y;
  logic out_valid;
  logic out_stall;
  logic out_hit;
  logic signed [CW-1:0] out_hit_x, out_hit_y;

  crossing_board board;
  int cycles;
  int items_sent;
  int stall_mode;

  segment_circle_intersect #(.COORD_WIDTH(CW)) dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_start_x(in_start_x), .in_start_y(in_start_y),
    .in_end_x(in_end_x), .in_end_y(in_end_y),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_hit(out_hit), .out_hit_x(out_hit_x), .out_hit_y(out_hit_y)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("segment_circle_intersect verification failed");
      $finish;
    end
  end

  // receiver stall pattern: runs of free flow, light and heavy stalling
  always @(posedge clk) begin
    if ($urandom_range(0, 99) == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 1) == 0);
      default: out_stall <= ($urandom_range(0, 9) != 0);
    endcase
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) board.check(out_hit, out_hit_x, out_hit_y);
  end

  // one segment item, held until taken
  task drive_segment(logic signed [CW-1:0] sx, logic signed [CW-1:0] sy,
                     logic signed [CW-1:0] ex, logic signed [CW-1:0] ey);
    in_valid <= 1'b1;
    in_start_x <= sx;
    in_start_y <= sy;
    in_end_x <= ex;
    in_end_y <= ey;
    do @(posedge clk); while (in_stall);
    board.note(sx, sy, ex, ey);
    items_sent++;
  endtask

  // wait until every result is back, then let the pipe drain
  task settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // one register write, then cfg_valid returns low on the write channel
  task write_reg(logic [1:0] idx, logic [CW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    board.set_reg(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task set_circle(logic signed [CW-1:0] x, logic signed [CW-1:0] y, logic [CW-1:0] r);
    settle();
    write_reg(sci_pkg::REG_CENTER_X, x);
    write_reg(sci_pkg::REG_CENTER_Y, y);
    write_reg(sci_pkg::REG_RADIUS, r);
    @(posedge clk);
  endtask

  function logic signed [CW-1:0] near(logic signed [CW-1:0] ctr, longint span);
    longint v;
    v = longint'(ctr) + longint'($urandom_range(0, 32'(2 * span))) - span;
    return v[CW-1:0];
  endfunction

  // mostly segments around the circle, some anywhere in the plane
  task random_phase(int count);
    longint span;
    int burst;
    int sent;
    logic signed [CW-1:0] sx, sy;
    sent = 0;
    span = 2 * longint'(board.radius) + 512;
    if (span > 64'd2000000000) span = 64'd2000000000;
    while (sent < count) begin
      burst = $urandom_range(1, 24);
      for (int i = 0; i < burst && sent < count; i++) begin
        case ($urandom_range(0, 9))
          0, 1: drive_segment(CW'($urandom), CW'($urandom), CW'($urandom), CW'($urandom));
          2: begin
            sx = near(board.cx, span);
            sy = near(board.cy, span);
            drive_segment(sx, sy, sx, sy);
          end
          3: begin
            sx = near(board.cx, span);
            drive_segment(sx, near(board.cy, span), sx, near(board.cy, span));
          end
          default:
            drive_segment(near(board.cx, span), near(board.cy, span),
                          near(board.cx, span), near(board.cy, span));
        endcase
        sent++;
      end
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  endtask

  initial begin
    board = new();
    cycles = 0;
    items_sent = 0;
    stall_mode = 0;
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_start_x = '0;
    in_start_y = '0;
    in_end_x = '0;
    in_end_y = '0;
    out_stall = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset circle is a point at the origin
    drive_segment(-24'sd256, 24'sd0, 24'sd256, 24'sd0);
    drive_segment(24'sd100, 24'sd100, 24'sd100, 24'sd100);
    set_circle(24'sd0, 24'sd0, 24'd2560);
    // zero-length, miss, tangent, start inside, end short of circle, crossing
    drive_segment(24'sd0, 24'sd0, 24'sd0, 24'sd0);
    drive_segment(24'sd5000, 24'sd5000, 24'sd9000, 24'sd5000);
    drive_segment(-24'sd5000, 24'sd2560, 24'sd5000, 24'sd2560);
    drive_segment(24'sd0, 24'sd0, 24'sd5000, 24'sd0);
    drive_segment(-24'sd9000, 24'sd0, -24'sd4000, 24'sd0);
    drive_segment(-24'sd9000, 24'sd7, 24'sd9000, -24'sd3);
    drive_segment(24'sd3000, 24'sd3000, -24'sd3000, -24'sd3000);
    drive_segment(24'sd0, -24'sd2560, 24'sd0, -24'sd2560);
    drive_segment(24'sd2559, 24'sd0, 24'sd2561, 24'sd0);
    // extremes of the coordinates
    drive_segment(C_MIN, C_MIN, C_MAX, C_MAX);
    drive_segment(C_MAX, C_MIN, C_MIN, C_MAX);
    drive_segment(C_MIN, 24'sd0, C_MAX, 24'sd0);
    drive_segment(C_MAX, C_MAX, C_MAX, C_MAX);
    drive_segment(C_MIN, C_MAX, C_MIN, C_MIN);
    random_phase(110);

    // largest radius, extreme centers; unused index and dropped top bit
    set_circle(C_MAX, C_MIN, 24'hffffff);
    write_reg(REG_SPARE, 24'h123456);
    drive_segment(C_MIN, C_MAX, C_MAX, C_MIN);
    drive_segment(C_MAX, C_MIN, C_MAX, C_MIN);
    random_phase(120);

    set_circle(C_MIN, C_MAX, 24'd0);
    drive_segment(C_MIN, C_MAX, C_MIN, C_MAX);
    drive_segment(C_MAX, C_MAX, C_MIN, C_MAX);
    random_phase(120);

    for (int p = 0; p < 4; p++) begin
      set_circle(CW'($urandom), CW'($urandom), CW'($urandom_range(0, 1 << (6 + 4 * p))));
      write_reg(REG_SPARE, CW'($urandom));
      random_phase(95);
    end

    set_circle(24'sd1000, -24'sd700, 24'd300);
    random_phase(100);

    settle();
    $display("sent %0d segments over several circle settings, %0d results checked, %0d hits",
             items_sent, board.checked, board.hits_seen);
    if (board.mismatches == 0 && board.pending_q.size() == 0) begin
      $display("segment_circle_intersect verification clean");
    end else begin
      $display("segment_circle_intersect verification failed");
    end
    $finish;
  end
endmodule
